/* sv/cle_pkg.sv */
// Shared types and constants for the console line editor.
// Depends on nothing; the interfaces and the top level import it.
package cle_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned LenW  = 6;

  localparam logic [ByteW-1:0] KeyCancel  = 8'h03;
  localparam logic [ByteW-1:0] KeyBs      = 8'h08;
  localparam logic [ByteW-1:0] KeyLf      = 8'h0A;
  localparam logic [ByteW-1:0] KeyCr      = 8'h0D;
  localparam logic [ByteW-1:0] KeyEsc     = 8'h1B;
  localparam logic [ByteW-1:0] KeyBracket = 8'h5B;
  localparam logic [ByteW-1:0] KeyRight   = 8'h43;
  localparam logic [ByteW-1:0] KeyLeft    = 8'h44;
  localparam logic [ByteW-1:0] KeyDel     = 8'h7F;
  localparam logic [ByteW-1:0] PrintLo    = 8'h20;
  localparam logic [ByteW-1:0] PrintHi    = 8'h7E;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
    logic [LenW-1:0]  line_length;
    logic             is_empty;
    logic             cancelled;
  } cle_result_t;

endpackage

/* sv/cle_if.sv */
// Valid/ready channels of the console line editor: byte in, line result out.
// Depends on cle_pkg.
interface cle_in_if;
  import cle_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cle_out_if;
  import cle_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             is_last;
  logic [LenW-1:0]  line_length;
  logic             is_empty;
  logic             cancelled;
  modport source (output valid, output char_code, output is_last, output line_length,
                  output is_empty, output cancelled, input ready);
  modport sink   (input valid, input char_code, input is_last, input line_length,
                  input is_empty, input cancelled, output ready);
endinterface

/* sv/console_line_editor.sv */
// Console line editor top level: line store memory and its edit/emit sequencer.
// Depends on cle_pkg and the channel interfaces in cle_if.sv.
//
// Usage: console bytes arrive one beat at a time on in_i. Printable bytes are
// inserted at the cursor, DEL/BS deletes before it, ESC [ D / ESC [ C move
// the cursor. CR or LF sends the line on out_o, one beat per byte with
// is_last on the final one; an empty line sends one beat with is_empty set.
// Byte 3 sends one cancelled beat. Both clear the line.
// Sequencing: cursor moves, appends at the end and deletes of the last byte are
// done in S_IDLE itself. An insert inside the line moves each byte after the
// cursor one place right in S_INS, then writes the new byte in S_PUT; a delete
// inside the line moves each byte after the cursor one place left in S_DEL.
// Both move one byte at a time, as the line store has a single write port. A
// line leaves at one beat per cycle when out_o is not stalled.
// out_o has a one-beat output register; a stalled receiver holds the
// sequencer in the emit step, and in_i.ready stays low until the last beat
// of the line is in the output register.
// Reset clears length, cursor and escape state; store contents are not reset.
module console_line_editor #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cle_in_if.sink       in_i,
  cle_out_if.source    out_o
);
  import cle_pkg::*;

  localparam int unsigned IdxW = $clog2(LINE_CAPACITY);
  localparam logic [IdxW-1:0] LenMax = IdxW'(LINE_CAPACITY - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_DEL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  esc_e              esc_q, esc_d;
  logic              esc_br_q, esc_br_d;
  logic [CharW-1:0]  byte_q, byte_d;
  logic              single_q, single_d;
  logic              cancel_q, cancel_d;
  logic              out_valid_q, out_valid_d;
  cle_result_t       out_q, out_d;

  logic [CharW-1:0]  mem_q [LINE_CAPACITY];
  logic [CharW-1:0]  rd_data_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_wa, mem_ra;
  logic [CharW-1:0]  mem_wd;

  logic              acc, slot_free, out_load;
  logic [ByteW-1:0]  b;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign slot_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cur_d    = cur_q;
    ptr_d    = ptr_q;
    esc_d    = esc_q;
    esc_br_d = esc_br_q;
    byte_d   = byte_q;
    single_d = single_q;
    cancel_d = cancel_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = '0;
    mem_ra   = '0;
    mem_wd   = '0;
    out_load = 1'b0;
    out_d    = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          priority if (esc_q == ESC_FIRST) begin
            esc_br_d = (b == KeyBracket);
            esc_d    = ESC_SECOND;
          end else if (esc_q != ESC_NONE) begin
            if (esc_br_q) begin
              if (b == KeyLeft && cur_q != '0) begin
                cur_d = cur_q - IdxW'(1);
              end else if (b == KeyRight && cur_q < len_q) begin
                cur_d = cur_q + IdxW'(1);
              end
            end
            esc_d    = ESC_NONE;
            esc_br_d = 1'b0;
          end else if (b == KeyLf || b == KeyCr) begin
            single_d = (len_q == '0);
            cancel_d = 1'b0;
            mem_re   = (len_q != '0);
            mem_ra   = '0;
            ptr_d    = '0;
            state_d  = S_EMIT;
          end else if (b == KeyDel || b == KeyBs) begin
            if (cur_q != '0) begin
              if (cur_q == len_q) begin
                len_d = len_q - IdxW'(1);
                cur_d = cur_q - IdxW'(1);
              end else begin
                mem_re  = 1'b1;
                mem_ra  = cur_q;
                ptr_d   = cur_q - IdxW'(1);
                state_d = S_DEL;
              end
            end
          end else if (b == KeyEsc) begin
            esc_d    = ESC_FIRST;
            esc_br_d = 1'b0;
          end else if (b == KeyCancel) begin
            single_d = 1'b1;
            cancel_d = 1'b1;
            state_d  = S_EMIT;
          end else if (b >= PrintLo && b <= PrintHi) begin
            if (len_q != LenMax) begin
              if (cur_q == len_q) begin
                mem_we = 1'b1;
                mem_wa = cur_q;
                mem_wd = b[CharW-1:0];
                len_d  = len_q + IdxW'(1);
                cur_d  = cur_q + IdxW'(1);
              end else begin
                mem_re  = 1'b1;
                mem_ra  = len_q - IdxW'(1);
                ptr_d   = len_q;
                byte_d  = b[CharW-1:0];
                state_d = S_INS;
              end
            end
          end else begin
            // other control bytes and codes above 0x7F are dropped
          end
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = rd_data_q;
        if (ptr_q == cur_q + IdxW'(1)) begin
          state_d = S_PUT;
        end else begin
          mem_re = 1'b1;
          mem_ra = ptr_q - IdxW'(2);
          ptr_d  = ptr_q - IdxW'(1);
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = cur_q;
        mem_wd  = byte_q;
        len_d   = len_q + IdxW'(1);
        cur_d   = cur_q + IdxW'(1);
        state_d = S_IDLE;
      end
      S_DEL: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = rd_data_q;
        if ((IdxW+1)'(ptr_q) + (IdxW+1)'(2) == (IdxW+1)'(len_q)) begin
          len_d   = len_q - IdxW'(1);
          cur_d   = cur_q - IdxW'(1);
          state_d = S_IDLE;
        end else begin
          mem_re = 1'b1;
          mem_ra = ptr_q + IdxW'(2);
          ptr_d  = ptr_q + IdxW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (single_q) begin
            out_d.char_code   = '0;
            out_d.is_last     = 1'b1;
            out_d.line_length = '0;
            out_d.is_empty    = 1'b1;
            out_d.cancelled   = cancel_q;
            len_d             = '0;
            cur_d             = '0;
            state_d           = S_IDLE;
          end else begin
            out_d.char_code   = rd_data_q;
            out_d.is_last     = (ptr_q + IdxW'(1) == len_q);
            out_d.line_length = LenW'(len_q);
            out_d.is_empty    = 1'b0;
            out_d.cancelled   = 1'b0;
            if (ptr_q + IdxW'(1) == len_q) begin
              len_d   = '0;
              cur_d   = '0;
              state_d = S_IDLE;
            end else begin
              mem_re = 1'b1;
              mem_ra = ptr_q + IdxW'(1);
              ptr_d  = ptr_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      ptr_q       <= '0;
      esc_q       <= ESC_NONE;
      esc_br_q    <= 1'b0;
      single_q    <= 1'b0;
      cancel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      ptr_q       <= ptr_d;
      esc_q       <= esc_d;
      esc_br_q    <= esc_br_d;
      single_q    <= single_d;
      cancel_q    <= cancel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.char_code   = out_q.char_code;
  assign out_o.is_last     = out_q.is_last;
  assign out_o.line_length = out_q.line_length;
  assign out_o.is_empty    = out_q.is_empty;
  assign out_o.cancelled   = out_q.cancelled;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for console_line_editor: drives console bytes, predicts
// the emitted line beats and compares every result field.
// Depends on cle_pkg, the channel interfaces in cle_if.sv and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int unsigned Cap        = 64;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 6;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  console_line_editor #(
    .LINE_CAPACITY (Cap)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predicted editor state
  logic [CharW-1:0] line_mem [Cap];
  int unsigned      line_len = 0;
  int unsigned      cur_pos = 0;
  esc_e             esc_phase = ESC_NONE;
  logic             esc_bracket = 1'b0;

  cle_result_t      line_exp_q [$];
  logic [ByteW-1:0] byte_q [$];
  int unsigned      bytes_pushed;
  int unsigned      bytes_taken = 0;
  int unsigned      err_cnt = 0;
  int unsigned      in_idle_pct;
  int unsigned      out_stall_pct;
  int unsigned      hold_req;
  int unsigned      hold_ack;
  int unsigned      hold_left;
  int unsigned      stall_cycles = 0;

  function automatic void emit_beat(input logic [CharW-1:0] code, input logic last,
                                    input int unsigned len, input logic empty,
                                    input logic cancel);
    cle_result_t res;
    res.char_code   = code;
    res.is_last     = last;
    res.line_length = len[LenW-1:0];
    res.is_empty    = empty;
    res.cancelled   = cancel;
    line_exp_q.push_back(res);
  endfunction

  function automatic void predict_byte(input logic [ByteW-1:0] b);
    int unsigned i;
    if (esc_phase == ESC_FIRST) begin
      esc_bracket = (b == KeyBracket);
      esc_phase   = ESC_SECOND;
    end else if (esc_phase == ESC_SECOND) begin
      if (esc_bracket) begin
        if (b == KeyLeft && cur_pos > 0) cur_pos--;
        else if (b == KeyRight && cur_pos < line_len) cur_pos++;
      end
      esc_phase   = ESC_NONE;
      esc_bracket = 1'b0;
    end else if (b == KeyLf || b == KeyCr) begin
      if (line_len == 0) begin
        emit_beat('0, 1'b1, 0, 1'b1, 1'b0);
      end else begin
        for (i = 0; i < line_len; i++) begin
          emit_beat(line_mem[i], (i + 1 == line_len), line_len, 1'b0, 1'b0);
        end
      end
      line_len = 0;
      cur_pos  = 0;
    end else if (b == KeyDel || b == KeyBs) begin
      if (cur_pos > 0) begin
        for (i = cur_pos - 1; i + 1 < line_len; i++) line_mem[i] = line_mem[i + 1];
        line_len--;
        cur_pos--;
      end
    end else if (b == KeyEsc) begin
      esc_phase   = ESC_FIRST;
      esc_bracket = 1'b0;
    end else if (b == KeyCancel) begin
      emit_beat('0, 1'b1, 0, 1'b1, 1'b1);
      line_len = 0;
      cur_pos  = 0;
    end else if (b >= PrintLo && b <= PrintHi && line_len < Cap - 1) begin
      for (i = line_len; i > cur_pos; i--) line_mem[i] = line_mem[i - 1];
      line_mem[cur_pos] = b[CharW-1:0];
      line_len++;
      cur_pos++;
    end
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    logic             nxt_valid;
    logic [ByteW-1:0] nxt_byte;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= '0;
    end else begin
      nxt_valid = in_ch.valid;
      nxt_byte  = in_ch.in_byte;
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.in_byte);
        bytes_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && byte_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_byte  = byte_q.pop_front();
      end
      in_ch.valid   <= nxt_valid;
      in_ch.in_byte <= nxt_byte;
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk or negedge rst_n) begin
    cle_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_ack     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_exp_q.size() == 0) begin
          $error("unexpected result beat: char_code %0d is_last %0d line_length %0d",
                 out_ch.char_code, out_ch.is_last, out_ch.line_length);
          err_cnt++;
        end else begin
          want = line_exp_q.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            $error("char_code: expected %0d, got %0d", want.char_code, out_ch.char_code);
            err_cnt++;
          end
          if (out_ch.is_last !== want.is_last) begin
            $error("is_last: expected %0d, got %0d", want.is_last, out_ch.is_last);
            err_cnt++;
          end
          if (out_ch.line_length !== want.line_length) begin
            $error("line_length: expected %0d, got %0d", want.line_length,
                   out_ch.line_length);
            err_cnt++;
          end
          if (out_ch.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_ch.is_empty);
            err_cnt++;
          end
          if (out_ch.cancelled !== want.cancelled) begin
            $error("cancelled: expected %0d, got %0d", want.cancelled, out_ch.cancelled);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack     <= hold_req;
        hold_left    <= HoldCycles;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    byte_q.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_arrow(input logic [ByteW-1:0] dir);
    push_byte(KeyEsc);
    push_byte(KeyBracket);
    push_byte(dir);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_taken != bytes_pushed || line_exp_q.size() != 0);
  endtask

  // one editing session: random edits, usually closed by a line end or a cancel
  task automatic push_session(input int unsigned max_ops);
    int unsigned n_ops;
    int unsigned k;
    int unsigned r;
    n_ops = $urandom_range(max_ops, 1);
    for (k = 0; k < n_ops; k++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        push_byte(ByteW'($urandom_range(PrintHi, PrintLo)));
      end else if (r < 65) begin
        push_arrow(KeyLeft);
      end else if (r < 72) begin
        push_arrow(KeyRight);
      end else if (r < 80) begin
        push_byte($urandom_range(1) ? KeyDel : KeyBs);
      end else if (r < 85) begin
        push_byte(KeyEsc);
        push_byte(ByteW'($urandom_range(255)));
        push_byte(ByteW'($urandom_range(255)));
      end else if (r < 90) begin
        push_byte(ByteW'($urandom_range(255)));
      end else begin
        push_byte(ByteW'($urandom_range(PrintHi, PrintLo)));
      end
    end
    r = $urandom_range(99);
    if (r < 80) push_byte($urandom_range(1) ? KeyCr : KeyLf);
    else if (r < 92) push_byte(KeyCancel);
  endtask

  initial begin
    int unsigned ph;
    int unsigned k;
    int unsigned mark;
    rst_n         = 1'b0;
    bytes_pushed  = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_req      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty line, cancel, cursor bounds, field extremes, escapes
    push_byte(KeyCr);
    push_byte(KeyCancel);
    push_byte("A");
    push_arrow(KeyLeft);
    push_arrow(KeyLeft);
    push_byte(PrintHi);
    push_byte(PrintLo);
    push_arrow(KeyRight);
    push_arrow(KeyRight);
    push_byte(KeyDel);
    push_byte(KeyEsc);
    push_byte(KeyCr);
    push_byte(KeyLf);
    push_byte(KeyEsc);
    push_byte("x");
    push_byte(KeyLeft);
    push_byte(8'h80);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(KeyLf);
    push_byte(KeyBs);
    push_byte("z");
    push_byte(KeyCancel);
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   <= 0;
          out_stall_pct <= 0;
        end
        1: begin
          in_idle_pct   <= 55;
          out_stall_pct <= 0;
        end
        2: begin
          in_idle_pct   <= 0;
          out_stall_pct <= 55;
        end
        default: begin
          in_idle_pct   <= 15;
          out_stall_pct <= 15;
        end
      endcase
      if (ph == 0) begin
        // full store: overfill, edit inside the full line, then send it
        for (k = 0; k < Cap + 4; k++) push_byte(ByteW'($urandom_range(PrintHi, PrintLo)));
        push_arrow(KeyLeft);
        push_arrow(KeyLeft);
        push_byte("#");
        push_byte(KeyBs);
        push_byte("%");
        push_byte(KeyCr);
        wait_drained();
        hold_req <= hold_req + 1;
        // two-beat line during the hold, so the input stalls behind it
        push_byte("a");
        push_byte("b");
        push_byte(KeyCr);
      end
      mark = bytes_pushed;
      while (bytes_pushed - mark < PhaseItems) push_session(8);
      push_byte(KeyCr);
      wait_drained();
    end

    repeat (80) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cle_pkg.sv
sv/cle_if.sv
sv/console_line_editor.sv
dv/tb_top.sv
